// ===== hdl/spq_pkg.sv =====
// types, constants and codes shared by the stable priority queue
// no dependencies
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FILL_W   = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] item_value;
      logic signed [15:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_value;
      logic signed [15:0] out_priority;
      logic [4:0]         fill_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [15:0] prio;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      ins_en;
      logic      del_en;
      entry_type entry;
   } cell_ctrl_type;

   // what a cell shows its right neighbour
   typedef struct packed {
      logic      occ;
      entry_type entry;
   } link_type;

   localparam signed [15:0] PRIO_MIN = 16'sh8000;

endpackage

// ===== hdl/stable_priority_queue_top.sv =====
// top level of the stable priority queue: control, fill count, result register
// depends on spq_pkg and spq_cell
//
// usage
//   request channel req_valid/req_ready/req_data carries one operation:
//   insert (value and priority) or delete of the head entry
//   result channel rsp_valid/rsp_ready/rsp_data returns one result per
//   request: status, removed value and priority, and the fill count after it
//   the entries sit in a row of CAPACITY cells kept sorted by priority,
//   smallest first, equal priorities in arrival order; every cell compares
//   its entry with the new one and shifts from a neighbour in the same cycle
//   rsp_valid rises in the cycle after acceptance; a new request is
//   taken every cycle, set by the compare and shift of the cell row, as
//   long as the result register is empty or being drained
//   while rsp_ready is low and a result waits, req_ready drops and the
//   queue holds its state
//   reset clears the fill count and the result valid; cell contents are
//   left alone and only slots below the fill count are ever looked at
module stable_priority_queue_top
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             accept;
   logic             full;
   logic             empty;
   cell_ctrl_type    ctrl;
   logic             occ     [CAPACITY];
   entry_type        entries [CAPACITY];

   // result register may be refilled when empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl.ins_en             = accept && (req_data.operation == OP_INSERT) && !full;
      ctrl.del_en             = accept && (req_data.operation == OP_DELETE) && !empty;
      ctrl.entry.value        = req_data.item_value;
      ctrl.entry.prio         = req_data.priority_req;
   end

   // occupancy of each slot from the fill count
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         link_type  left;
         entry_type right;

         assign occ[gi] = (CNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_first
            // head sees an occupied neighbour of lowest priority, so it never
            // shifts from the left but may take the new entry
            assign left.occ        = 1'b1;
            assign left.entry.value = '0;
            assign left.entry.prio  = PRIO_MIN;
         end else begin : g_inner
            assign left.occ   = occ[gi-1];
            assign left.entry = entries[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right = '0;
         end else begin : g_mid
            assign right = entries[gi+1];
         end

         spq_cell u_cell (
            .clock   (clock),
            .ctrl    (ctrl),
            .own_occ (occ[gi]),
            .left    (left),
            .right   (right),
            .entry   (entries[gi])
         );
      end
   endgenerate

   // fill count and result
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_value    = '0;
         rsp_in.out_priority = '0;
         if (req_data.operation == OP_INSERT) begin
            if (full) begin
               rsp_in.status = ST_OVERFLOW;
            end else begin
               rsp_in.status = ST_INSERTED;
               count_in      = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               rsp_in.status = ST_UNDERFLOW;
            end else begin
               rsp_in.status       = ST_DELETED;
               rsp_in.out_value    = entries[0].value;
               rsp_in.out_priority = entries[0].prio;
               count_in            = count_ff - CNT_W'(1);
            end
         end
         rsp_in.fill_count = FILL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts from either neighbour
// depends on spq_pkg
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          own_occ,
   input  link_type      left,
   input  entry_type     right,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      load;

   always_comb begin
      entry_in = entry_ff;
      load     = 1'b0;
      if (ctrl.ins_en) begin
         if (left.occ && (left.entry.prio > ctrl.entry.prio)) begin
            // new entry lands somewhere to the left, make room
            entry_in = left.entry;
            load     = 1'b1;
         end else if (left.occ && (!own_occ || (entry_ff.prio > ctrl.entry.prio))) begin
            // left neighbour is not greater, this slot is the first greater or first free one
            entry_in = ctrl.entry;
            load     = 1'b1;
         end
      end else if (ctrl.del_en) begin
         entry_in = right;
         load     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== tb/tb_stable_priority_queue_top.sv =====
// testbench for the stable priority queue: directed and random insert and delete requests
// every result is checked against a behavioural copy of the sorted queue
// depends on spq_pkg and stable_priority_queue_top
module tb_stable_priority_queue_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // well above the slowest correct run: about 1200 requests under heavy idling
   localparam int CYCLE_LIMIT  = 400000;
   // settle time after the last result, the block answers in the cycle after acceptance
   localparam int DRAIN_CYCLES = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // behavioural copy of the queue, sorted by priority, ties in arrival order
   entry_type shadow_entries [CAPACITY];
   int        shadow_fill = 0;
   // results still owed by the block, oldest first
   rsp_type   owed_results [$];

   int error_count = 0;
   int cycle_count = 0;
   // chance in percent of a sender gap and of a receiver stall in each cycle
   int idle_pct    = 0;
   int stall_pct   = 0;

   stable_priority_queue_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver back-pressure, changes only at the falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // applies one accepted request to the shadow queue and returns the result it owes
   function automatic rsp_type queue_outcome(req_type r);
      rsp_type o;
      int      pos;
      int      k;
      o = '0;
      if (r.operation == OP_INSERT) begin
         if (shadow_fill >= CAPACITY) begin
            // full: entry dropped, nothing moves
            o.status = ST_OVERFLOW;
         end else begin
            // new entry goes behind every entry of smaller or equal priority
            pos = 0;
            while (pos < shadow_fill &&
                   $signed(shadow_entries[pos].prio) <= $signed(r.priority_req))
               pos++;
            for (k = shadow_fill; k > pos; k--)
               shadow_entries[k] = shadow_entries[k - 1];
            shadow_entries[pos].value = r.item_value;
            shadow_entries[pos].prio  = r.priority_req;
            shadow_fill++;
            o.status = ST_INSERTED;
         end
      end else begin
         if (shadow_fill == 0) begin
            o.status = ST_UNDERFLOW;
         end else begin
            // head leaves, the rest moves up one place
            o.status       = ST_DELETED;
            o.out_value    = shadow_entries[0].value;
            o.out_priority = shadow_entries[0].prio;
            for (k = 1; k < shadow_fill; k++)
               shadow_entries[k - 1] = shadow_entries[k];
            shadow_fill--;
         end
      end
      o.fill_count = 5'(shadow_fill);
      return o;
   endfunction

   // predicts on every accepted request and checks every accepted result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // push before popping so the check does not depend on the latency
         if (req_valid && req_ready)
            owed_results.push_back(queue_outcome(req_data));
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("result with no request outstanding");
               error_count++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.out_value !== want.out_value) begin
                  $error("out_value expected %0d got %0d", want.out_value,
                         rsp_data.out_value);
                  error_count++;
               end
               if (rsp_data.out_priority !== want.out_priority) begin
                  $error("out_priority expected %0d got %0d", want.out_priority,
                         rsp_data.out_priority);
                  error_count++;
               end
               if (rsp_data.fill_count !== want.fill_count) begin
                  $error("fill_count expected %0d got %0d", want.fill_count,
                         rsp_data.fill_count);
                  error_count++;
               end
            end
         end
      end
   end

   // drives one request at the falling edge, with random gaps first, and holds it until taken
   task automatic send_request(input logic op, input logic signed [31:0] value,
                               input logic signed [15:0] prio);
      req_type r;
      r.operation    = op;
      r.item_value   = value;
      r.priority_req = prio;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!(req_valid && req_ready));
   endtask

   // deletes on an empty queue, with the ignored fields at their extremes
   task automatic test_underflow();
      send_request(OP_DELETE, 32'sh7fffffff, 16'sh7fff);
      send_request(OP_DELETE, 32'sh80000000, PRIO_MIN);
   endtask

   // fills the queue with extreme values and tied priorities, then one insert too many
   task automatic test_fill_and_overflow();
      logic signed [15:0] prios [CAPACITY] = '{
         PRIO_MIN, 16'sh7fff, 16'sh0000, 16'sh0000, -16'sd1, 16'sh0000, 16'sh7fff, PRIO_MIN,
         16'sd5, -16'sd5, 16'sh0000, 16'sd1, -16'sd1, 16'sh7fff, 16'sd100, -16'sd100};
      logic signed [31:0] values [CAPACITY] = '{
         32'sh7fffffff, 32'sh80000000, 32'sh00000000, -32'sd1, 32'sh55555555, 32'shaaaaaaaa,
         32'sd6, 32'sd7, 32'sd8, 32'sd9, 32'sd10, 32'sd11, 32'sd12, 32'sd13, 32'sd14,
         32'sd15};
      int i;
      for (i = 0; i < CAPACITY; i++)
         send_request(OP_INSERT, values[i], prios[i]);
      send_request(OP_INSERT, -32'sd1, -16'sd1);
   endtask

   // removes the first few heads: lowest priority first, ties in arrival order
   task automatic test_head_removal();
      int i;
      for (i = 0; i < 6; i++)
         send_request(OP_DELETE, 32'sh00000000, 16'sh0000);
   endtask

   // bursts that lean towards filling, draining or neither, so full and empty come often
   task automatic test_random_traffic(input int count, input int sender_idle,
                                      input int receiver_stall);
      int                 sent;
      int                 insert_pct;
      int                 run_len;
      int                 i;
      logic               op;
      logic signed [15:0] prio;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      sent      = 0;
      while (sent < count) begin
         case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 50;
         endcase
         run_len = $urandom_range(24, 4);
         for (i = 0; i < run_len && sent < count; i++) begin
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
            // in half the draws a handful of close priorities so that ties are common
            case ($urandom_range(9))
               0, 1, 2, 3, 4: prio = 16'($signed($urandom_range(3)) - 2);
               8:             prio = PRIO_MIN;
               9:             prio = 16'sh7fff;
               default:       prio = 16'($urandom);
            endcase
            send_request(op, 32'($urandom), prio);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_underflow();
      test_fill_and_overflow();
      test_head_removal();
      test_random_traffic(288, 0, 0);
      test_random_traffic(288, 70, 0);
      test_random_traffic(288, 0, 70);
      test_random_traffic(288, 26, 26);

      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
